// ===== hw/rtl/rsled_pkg.sv =====
package rsled_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_MODE        = 2'd0;
  localparam logic [1:0] REG_BLINK_COUNT = 2'd1;
  localparam logic [1:0] REG_ONE_CODE    = 2'd2;
  localparam logic [1:0] REG_ZERO_CODE   = 2'd3;

  // Mode codes; every other code is idle
  localparam logic [1:0] MODE_FLOW  = 2'd0;
  localparam logic [1:0] MODE_BLINK = 2'd1;

  // Reset values
  localparam logic [7:0] ONE_CODE_RESET  = 8'd248;
  localparam logic [7:0] ZERO_CODE_RESET = 8'd192;
  localparam logic [7:0] PAUSE_RESET     = 8'd100;

  // Channel slots of the accumulator array
  localparam logic [1:0] CH_ALPHA = 2'd0;
  localparam logic [1:0] CH_RED   = 2'd1;
  localparam logic [1:0] CH_GREEN = 2'd2;
  localparam logic [1:0] CH_BLUE  = 2'd3;

  // Scaled red blink color in GRB order: red = 255 * 15 / 255
  localparam logic [23:0] RED_FRAME = 24'h000F00;

  localparam int FRAME_BITS = 24;

  // Flow color table, alpha/red/green/blue from the top byte down
  localparam logic [31:0] COLOR_TABLE [8] = '{
    32'h0F0000FF, 32'h0F00FF00, 32'h0FFF0000, 32'h0F0000FF,
    32'h0F00FF00, 32'h0FFF0000, 32'h0F0000FF, 32'h0F00FF00
  };

  typedef enum logic [2:0] {
    BK_START,
    BK_PAUSE,
    BK_BLACK,
    BK_RED,
    BK_END
  } blink_kind_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       flow_start;
    logic       seg_adv;
    logic       blink_upd;
    logic       load_fixed;
    logic       fixed_red;
    logic       mul;
    logic       acc;
    logic       smul;
    logic       sdiv;
    logic       shift;
    logic [1:0] idx;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [1:0]  mode;
    logic        seg_done;
    blink_kind_t kind;
    logic        frame_end;
  } stat_t;

  function automatic logic [7:0] color_chan(input logic [2:0] idx, input logic [1:0] c);
    logic [31:0] word;
    logic [7:0]  res;
    word = COLOR_TABLE[idx];
    unique case (c)
      CH_ALPHA: res = word[31:24];
      CH_RED:   res = word[23:16];
      CH_GREEN: res = word[15:8];
      CH_BLUE:  res = word[7:0];
    endcase
    return res;
  endfunction

endpackage

// ===== hw/rtl/rsled_ctrl.sv =====
module rsled_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  rsled_pkg::stat_t  stat,
  output rsled_pkg::cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_SMUL,
    S_SDIV,
    S_SEND
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] ch_r, ch_nxt;
  logic       accept;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_SEND);
  assign accept    = in_valid && (state_r == S_IDLE);

  // Sequence one tick: decide, update channels and scale (flow only), then send the frame if any
  always_comb begin
    cmd       = '0;
    cmd.idx   = ch_r;
    state_nxt = state_r;
    ch_nxt    = ch_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (stat.mode == rsled_pkg::MODE_FLOW) begin
            if (stat.seg_done) begin
              cmd.seg_adv = 1'b1;
            end else begin
              cmd.flow_start = 1'b1;
              ch_nxt         = 2'd0;
              state_nxt      = S_MUL;
            end
          end else if (stat.mode == rsled_pkg::MODE_BLINK) begin
            cmd.blink_upd = 1'b1;
            case (stat.kind) inside
              rsled_pkg::BK_PAUSE, rsled_pkg::BK_BLACK: begin
                cmd.load_fixed = 1'b1;
                state_nxt      = S_SEND;
              end
              rsled_pkg::BK_RED: begin
                cmd.load_fixed = 1'b1;
                cmd.fixed_red  = 1'b1;
                state_nxt      = S_SEND;
              end
              default: ;
            endcase
          end
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (ch_r == 2'd3) begin
          ch_nxt    = 2'd0;
          state_nxt = S_SMUL;
        end else begin
          ch_nxt    = ch_r + 2'd1;
          state_nxt = S_MUL;
        end
      end
      S_SMUL: begin
        cmd.smul  = 1'b1;
        state_nxt = S_SDIV;
      end
      S_SDIV: begin
        cmd.sdiv = 1'b1;
        if (ch_r == 2'd2) begin
          state_nxt = S_SEND;
        end else begin
          ch_nxt    = ch_r + 2'd1;
          state_nxt = S_SMUL;
        end
      end
      S_SEND: begin
        cmd.shift = out_ready;
        if (out_ready && stat.frame_end) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state and channel counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ch_r    <= 2'd0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
    end
  end

endmodule

// ===== hw/rtl/rsled_dp.sv =====
module rsled_dp #(
  parameter int SEGMENT_MS  = 500,
  parameter int PAUSE_TICKS = 200,
  parameter int BLINK_TICKS = 100,
  parameter int FLOW_COLORS = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [7:0]       cfg_data,
  input  logic [7:0]       in_elapsed_ms,
  input  rsled_pkg::cmd_t  cmd,
  output rsled_pkg::stat_t stat,
  output logic [7:0]       out_code_byte,
  output logic             out_frame_last
);

  localparam logic [2:0] LAST_SEG  = 3'(FLOW_COLORS - 1);
  localparam logic [9:0] SEG_END   = 10'(SEGMENT_MS);
  localparam logic [7:0] PAUSE_LD  = 8'(PAUSE_TICKS);
  localparam logic [6:0] HALF_TCK  = 7'(BLINK_TICKS / 2);
  localparam logic [6:0] FULL_TCK  = 7'(BLINK_TICKS);
  localparam logic [4:0] LAST_BIT  = 5'(rsled_pkg::FRAME_BITS - 1);

  // Q.16 step of a color difference over one segment, truncated toward zero
  function automatic logic signed [16:0] calc_step(input int diff);
    int q;
    q = (diff * 65536) / SEGMENT_MS;
    if (q > 65535) q = 65535;
    if (q < -65536) q = -65536;
    return 17'(q);
  endfunction

  function automatic logic [7:0] chan_val(input logic signed [25:0] a);
    logic [7:0] v;
    if (a[25]) v = 8'd0;
    else if (a[24]) v = 8'd255;
    else v = a[23:16];
    return v;
  endfunction

  // Scaling order on the wire: green, red, blue
  function automatic logic [1:0] scale_src(input logic [1:0] k);
    logic [1:0] s;
    unique case (k)
      2'd0:    s = rsled_pkg::CH_GREEN;
      2'd1:    s = rsled_pkg::CH_RED;
      default: s = rsled_pkg::CH_BLUE;
    endcase
    return s;
  endfunction

  // Step table per segment and channel, fixed at elaboration
  logic signed [16:0] step_tab [8][4];

  for (genvar gi = 0; gi < 8; gi++) begin : g_seg
    for (genvar gc = 0; gc < 4; gc++) begin : g_chan
      localparam int D = int'(rsled_pkg::color_chan(3'(gi + 1), 2'(gc)))
                       - int'(rsled_pkg::color_chan(3'(gi), 2'(gc)));
      localparam logic signed [16:0] S = calc_step(D);
      assign step_tab[gi][gc] = S;
    end
  end

  logic [1:0]         mode_r;
  logic [7:0]         blink_count_r, one_code_r, zero_code_r;
  logic [2:0]         seg_idx_r, seg_idx_nxt;
  logic [9:0]         seg_time_r;
  logic signed [25:0] acc_r [4];
  logic signed [16:0] step_r [4];
  logic [7:0]         bl_r, pl_r;
  logic [6:0]         phase_r, phase_inc;
  logic [7:0]         e_r;
  logic signed [25:0] prod_r;
  logic [15:0]        sprod_r;
  logic [23:0]        frame_r;
  logic [4:0]         cnt_r;

  logic [10:0]        tsum;
  logic signed [26:0] acc_sum;
  logic signed [25:0] acc_sat;
  logic [16:0]        dsum;
  rsled_pkg::blink_kind_t kind;

  // Segment time and next segment
  assign tsum = {1'b0, seg_time_r} + 11'(in_elapsed_ms);

  always_comb begin
    seg_idx_nxt = seg_idx_r + 3'd1;
    if (seg_idx_nxt >= LAST_SEG) seg_idx_nxt = 3'd0;
  end

  // Saturating accumulator add
  assign acc_sum = {acc_r[cmd.idx][25], acc_r[cmd.idx]} + {prod_r[25], prod_r};

  always_comb begin
    if (acc_sum[26] != acc_sum[25]) begin
      acc_sat = acc_sum[26] ? {1'b1, 25'd0} : {1'b0, {25{1'b1}}};
    end else begin
      acc_sat = acc_sum[25:0];
    end
  end

  // Divide by 255: exact for products of two 8-bit values
  assign dsum = {1'b0, sprod_r} + 17'(sprod_r[15:8]) + 17'd1;

  // Classify the blink tick from current counters
  assign phase_inc = phase_r + 7'd1;

  always_comb begin
    if (bl_r == 8'd0 && pl_r == 8'd0) kind = rsled_pkg::BK_START;
    else if (bl_r == 8'd0) kind = rsled_pkg::BK_PAUSE;
    else if (phase_inc < HALF_TCK) kind = rsled_pkg::BK_BLACK;
    else if (phase_inc < FULL_TCK) kind = rsled_pkg::BK_RED;
    else kind = rsled_pkg::BK_END;
  end

  assign stat.mode      = mode_r;
  assign stat.seg_done  = (seg_time_r >= SEG_END);
  assign stat.kind      = kind;
  assign stat.frame_end = (cnt_r == LAST_BIT);

  assign out_code_byte  = frame_r[23] ? one_code_r : zero_code_r;
  assign out_frame_last = (cnt_r == LAST_BIT);

  // Control and effect state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= rsled_pkg::MODE_FLOW;
      blink_count_r <= 8'd0;
      one_code_r    <= rsled_pkg::ONE_CODE_RESET;
      zero_code_r   <= rsled_pkg::ZERO_CODE_RESET;
      seg_idx_r     <= 3'd0;
      seg_time_r    <= 10'd0;
      for (int c = 0; c < 4; c++) begin
        acc_r[2'(c)]  <= {2'b00, rsled_pkg::color_chan(3'd0, 2'(c)), 16'h0000};
        step_r[2'(c)] <= step_tab[0][2'(c)];
      end
      bl_r    <= 8'd0;
      pl_r    <= rsled_pkg::PAUSE_RESET;
      phase_r <= 7'd0;
      cnt_r   <= 5'd0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          rsled_pkg::REG_MODE:        mode_r        <= cfg_data[1:0];
          rsled_pkg::REG_BLINK_COUNT: blink_count_r <= cfg_data;
          rsled_pkg::REG_ONE_CODE:    one_code_r    <= cfg_data;
          rsled_pkg::REG_ZERO_CODE:   zero_code_r   <= cfg_data;
        endcase
      end
      if (cmd.flow_start) begin
        seg_time_r <= tsum[10] ? 10'h3FF : tsum[9:0];
        cnt_r      <= 5'd0;
      end
      // Advance to the next segment and load its start color and steps
      if (cmd.seg_adv) begin
        seg_time_r <= 10'd0;
        seg_idx_r  <= seg_idx_nxt;
        for (int c = 0; c < 4; c++) begin
          acc_r[2'(c)]  <= {2'b00, rsled_pkg::color_chan(seg_idx_nxt, 2'(c)), 16'h0000};
          step_r[2'(c)] <= step_tab[seg_idx_nxt][2'(c)];
        end
      end
      if (cmd.acc) begin
        acc_r[cmd.idx] <= acc_sat;
      end
      // Blink counters
      if (cmd.blink_upd) begin
        case (kind)
          rsled_pkg::BK_START: begin
            bl_r <= blink_count_r;
            pl_r <= PAUSE_LD;
          end
          rsled_pkg::BK_PAUSE: pl_r <= pl_r - 8'd1;
          rsled_pkg::BK_END: begin
            phase_r <= 7'd0;
            bl_r    <= bl_r - 8'd1;
          end
          default: phase_r <= phase_inc;
        endcase
      end
      if (cmd.load_fixed || cmd.shift) begin
        cnt_r <= cmd.load_fixed ? 5'd0 : cnt_r + 5'd1;
      end
    end
  end

  // Arithmetic and frame payload
  always_ff @(posedge clk) begin
    if (cmd.flow_start) e_r <= in_elapsed_ms;
    if (cmd.mul) prod_r <= step_r[cmd.idx] * $signed({1'b0, e_r});
    if (cmd.smul) begin
      sprod_r <= chan_val(acc_r[scale_src(cmd.idx)]) * chan_val(acc_r[rsled_pkg::CH_ALPHA]);
    end
    if (cmd.sdiv) begin
      frame_r <= {frame_r[15:0], dsum[15:8]};
    end else if (cmd.load_fixed) begin
      frame_r <= cmd.fixed_red ? rsled_pkg::RED_FRAME : 24'd0;
    end else if (cmd.shift) begin
      frame_r <= {frame_r[22:0], 1'b0};
    end
  end

endmodule

// ===== hw/rtl/rgb_status_led_effect_engine_top.sv =====
// Channel  Handshake              Payload
// -------  ---------------------  ----------------------------------
// in       in_valid / in_ready    in_elapsed_ms[7:0]
// out      out_valid / out_ready  out_code_byte[7:0], out_frame_last
// cfg      cfg_we                 cfg_index[1:0], cfg_data[7:0]
//
// One tick at a time: in_ready is high only while no tick is in work.
// Flow tick: four channel updates (multiply, accumulate) share one 17x9 multiplier, then
// three scale multiplies, then 24 code bytes; a segment-end tick loads the next segment.
// Blink tick: code bytes start the cycle after accept; ticks that show nothing end at accept.
// Synchronous active-low reset loads segment 0; out_ready low holds the current byte.
module rgb_status_led_effect_engine_top #(
  parameter int SEGMENT_MS  = 500,
  parameter int PAUSE_TICKS = 200,
  parameter int BLINK_TICKS = 100,
  parameter int FLOW_COLORS = 7
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_elapsed_ms,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_code_byte,
  output logic       out_frame_last,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  rsled_pkg::cmd_t  cmd;
  rsled_pkg::stat_t stat;

  rsled_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rsled_dp #(
    .SEGMENT_MS  (SEGMENT_MS),
    .PAUSE_TICKS (PAUSE_TICKS),
    .BLINK_TICKS (BLINK_TICKS),
    .FLOW_COLORS (FLOW_COLORS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_elapsed_ms  (in_elapsed_ms),
    .cmd            (cmd),
    .stat           (stat),
    .out_code_byte  (out_code_byte),
    .out_frame_last (out_frame_last)
  );

endmodule

// ===== hw/rtl/rsled_checker.sv =====
module rsled_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_frame_last
);

  // No new tick is taken while a frame is being sent
  a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while frame pending");

  // The frame ends with its last byte
  a_frame_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_frame_last |=> !out_valid)
    else $error("output still valid after last byte");

  // A fresh tick never starts on a last byte
  a_fresh_frame: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !(out_valid && out_frame_last))
    else $error("frame starts on last byte");

  // Stalled transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_last))
    else $error("stalled output transaction changed");

endmodule

bind rgb_status_led_effect_engine_top rsled_checker u_rsled_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_frame_last (out_frame_last)
);
